[src/bcdec_pkg.sv]
// ----------------------------------------------------------------------------
// bcdec_pkg: shared definitions for the BC1/BC2/BC3 block decoder
// Field widths, format codes and the small arithmetic helpers used to build
// the colour and alpha palettes.
// ----------------------------------------------------------------------------
package bcdec_pkg;

    localparam int WORD_W   = 64;
    localparam int RGBA_W   = 32;
    localparam int IDX_W    = 4;
    localparam int FMT_W    = 2;
    localparam int TEXELS   = 16;

    localparam logic [FMT_W-1:0] FMT_BC1 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_BC2 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_BC3 = 2'd2;

    localparam logic [IDX_W-1:0] LAST_TEXEL = 4'(TEXELS - 1);

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // Divide by constants through a scaled reciprocal; exact over the
    // ranges used (sum of three bytes for /3, seven or five bytes for /7, /5).
    function automatic logic [7:0] div3(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd2731;
        return p[20:13];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd6554;
        return p[22:15];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd4682;
        return p[22:15];
    endfunction

endpackage

[src/bcdec_if.sv]
// ----------------------------------------------------------------------------
// bcdec_if: channel interfaces of the block decoder
// Compressed block input, texel output and format register write channel.
// ----------------------------------------------------------------------------
interface bcdec_blk_if;
    logic                           valid;
    logic                           ready;
    logic [bcdec_pkg::WORD_W-1:0]   color_word;
    logic [bcdec_pkg::WORD_W-1:0]   alpha_word;

    modport source (output valid, color_word, alpha_word, input ready);
    modport sink   (input valid, color_word, alpha_word, output ready);
endinterface

interface bcdec_texel_if;
    logic                           valid;
    logic                           ready;
    logic [bcdec_pkg::IDX_W-1:0]    texel_index;
    logic [bcdec_pkg::RGBA_W-1:0]   texel_rgba;
    logic                           last_texel;

    modport source (output valid, texel_index, texel_rgba, last_texel, input ready);
    modport sink   (input valid, texel_index, texel_rgba, last_texel, output ready);
endinterface

interface bcdec_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bcdec_pkg::FMT_W-1:0]    block_format;

    modport source (output valid, block_format, input ready);
    modport sink   (input valid, block_format, output ready);
endinterface

[src/bc1_bc2_bc3_block_decoder.sv]
// ----------------------------------------------------------------------------
// bc1_bc2_bc3_block_decoder: S3TC 4x4 block to RGBA texel decoder
// Takes one compressed block per transaction and returns its sixteen texels
// in raster order, one texel transaction per cycle unless the output stalls,
// the sixteenth marked as last. The format register picks BC1, BC2 or BC3
// (code 3 decodes as BC1); the user must write it only while no block is in
// flight, which the block itself does not enforce. A block passes an input
// register, then combinational palette building into a palette register,
// from which the texel output register is loaded once per cycle while not
// stalled. Each block holds the palette register for its sixteen texels, so
// the throughput is set by the single texel output port; the next block is
// taken into the input register while the current one is still being
// emitted. No clearing pass after reset.
// ----------------------------------------------------------------------------
module bc1_bc2_bc3_block_decoder
(
    input  logic              clk,
    input  logic              rst_n,
    bcdec_cfg_if.sink         cfg,
    bcdec_blk_if.sink         blk,
    bcdec_texel_if.source     texel
);

    logic [bcdec_pkg::FMT_W-1:0]    fmt_reg;

    // input register
    logic                           v1_reg;
    logic [bcdec_pkg::WORD_W-1:0]   cw1_reg;
    logic [bcdec_pkg::WORD_W-1:0]   aw1_reg;
    logic [bcdec_pkg::FMT_W-1:0]    fmt1_reg;

    // palette register
    logic                           v2_reg;
    logic [bcdec_pkg::IDX_W-1:0]    cnt_reg;
    logic [bcdec_pkg::RGBA_W-1:0]   pal_reg [4];
    logic [7:0]                     ap_reg [8];
    logic [31:0]                    cidx_reg;
    logic [bcdec_pkg::WORD_W-1:0]   aw2_reg;
    logic [bcdec_pkg::FMT_W-1:0]    fmt2_reg;

    // texel output register
    logic                           tv_reg;
    logic [bcdec_pkg::IDX_W-1:0]    tidx_reg;
    logic [bcdec_pkg::RGBA_W-1:0]   trgba_reg;
    logic                           tlast_reg;

    logic                           out_load;
    logic                           emit;
    logic                           s2_free;
    logic                           s1_move;
    logic                           blk_acc;

    logic [bcdec_pkg::RGBA_W-1:0]   pal_next [4];
    logic [7:0]                     ap_next [8];
    logic [bcdec_pkg::RGBA_W-1:0]   trgba_next;

    assign out_load = !tv_reg || texel.ready;
    assign emit     = v2_reg && out_load;
    assign s2_free  = !v2_reg || (emit && cnt_reg == bcdec_pkg::LAST_TEXEL);
    assign s1_move  = v1_reg && s2_free;
    assign blk.ready = !v1_reg || s2_free;
    assign blk_acc  = blk.valid && blk.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= bcdec_pkg::FMT_BC1;
        end
        else if (cfg.valid)
        begin
            fmt_reg <= cfg.block_format;
        end
    end

    // Input register: fold the unused format code onto BC1 here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (blk.ready)
        begin
            v1_reg <= blk.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_acc)
        begin
            cw1_reg  <= blk.color_word;
            aw1_reg  <= blk.alpha_word;
            fmt1_reg <= (fmt_reg inside {bcdec_pkg::FMT_BC2, bcdec_pkg::FMT_BC3})
                        ? fmt_reg : bcdec_pkg::FMT_BC1;
        end
    end

    // Palette build
    always_comb
    begin
        logic [15:0] e0;
        logic [15:0] e1;
        logic [7:0]  c0 [3];
        logic [7:0]  c1 [3];
        logic [7:0]  p2 [3];
        logic [7:0]  p3 [3];
        logic [10:0] s2;
        logic [10:0] s3;
        logic [8:0]  s_half;
        logic        four;
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [10:0] a0w;
        logic [10:0] a1w;
        logic [10:0] s7;
        logic [10:0] s5;

        e0 = cw1_reg[15:0];
        e1 = cw1_reg[31:16];
        c0[0] = bcdec_pkg::widen5(e0[15:11]);
        c0[1] = bcdec_pkg::widen6(e0[10:5]);
        c0[2] = bcdec_pkg::widen5(e0[4:0]);
        c1[0] = bcdec_pkg::widen5(e1[15:11]);
        c1[1] = bcdec_pkg::widen6(e1[10:5]);
        c1[2] = bcdec_pkg::widen5(e1[4:0]);
        four = (fmt1_reg != bcdec_pkg::FMT_BC1) || (e0 > e1);

        for (int k = 0; k < 3; k++)
        begin
            s2 = {2'b00, c0[k], 1'b0} + {3'b000, c1[k]};
            s3 = {3'b000, c0[k]} + {2'b00, c1[k], 1'b0};
            s_half = {1'b0, c0[k]} + {1'b0, c1[k]};
            p2[k] = four ? bcdec_pkg::div3(s2) : s_half[8:1];
            p3[k] = bcdec_pkg::div3(s3);
        end

        pal_next[0] = {8'hFF, c0[2], c0[1], c0[0]};
        pal_next[1] = {8'hFF, c1[2], c1[1], c1[0]};
        pal_next[2] = {8'hFF, p2[2], p2[1], p2[0]};
        pal_next[3] = four ? {8'hFF, p3[2], p3[1], p3[0]} : '0;

        a0  = aw1_reg[7:0];
        a1  = aw1_reg[15:8];
        a0w = {3'b000, a0};
        a1w = {3'b000, a1};
        ap_next[0] = a0;
        ap_next[1] = a1;
        for (int k = 0; k < 6; k++)
        begin
            s7 = 11'(a0w * 11'(6 - k)) + 11'(a1w * 11'(1 + k));
            s5 = 11'(a0w * 11'((4 - k) & 7)) + 11'(a1w * 11'(1 + k));
            if (a0 > a1)
            begin
                ap_next[k + 2] = bcdec_pkg::div7(s7);
            end
            else if (k < 4)
            begin
                ap_next[k + 2] = bcdec_pkg::div5(s5);
            end
            else if (k == 4)
            begin
                ap_next[k + 2] = 8'h00;
            end
            else
            begin
                ap_next[k + 2] = 8'hFF;
            end
        end
    end

    // Palette register: hold a block for sixteen texels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (s2_free)
            begin
                v2_reg <= v1_reg;
            end
            if (emit)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pal_reg[i] <= pal_next[i];
            end
            for (int i = 0; i < 8; i++)
            begin
                ap_reg[i] <= ap_next[i];
            end
            cidx_reg <= cw1_reg[63:32];
            aw2_reg  <= aw1_reg;
            fmt2_reg <= fmt1_reg;
        end
    end

    // Texel select
    always_comb
    begin
        logic [1:0]  ci;
        logic [3:0]  a4;
        logic [5:0]  abase;
        logic [47:0] aidx;
        logic [2:0]  ai;
        logic [bcdec_pkg::RGBA_W-1:0] px;

        ci    = cidx_reg[{cnt_reg, 1'b0} +: 2];
        px    = pal_reg[ci];
        a4    = aw2_reg[{cnt_reg, 2'b00} +: 4];
        aidx  = aw2_reg[63:16];
        abase = {1'b0, cnt_reg, 1'b0} + {2'b00, cnt_reg};
        ai    = aidx[abase +: 3];
        case (fmt2_reg)
            bcdec_pkg::FMT_BC2: trgba_next = {a4, a4, px[23:0]};
            bcdec_pkg::FMT_BC3: trgba_next = {ap_reg[ai], px[23:0]};
            default:            trgba_next = px;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= 1'b0;
        end
        else if (out_load)
        begin
            tv_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            tidx_reg  <= cnt_reg;
            trgba_reg <= trgba_next;
            tlast_reg <= (cnt_reg == bcdec_pkg::LAST_TEXEL);
        end
    end

    assign texel.valid       = tv_reg;
    assign texel.texel_index = tidx_reg;
    assign texel.texel_rgba  = trgba_reg;
    assign texel.last_texel  = tlast_reg;

`ifndef ASSERT_OFF
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        texel.valid |-> (texel.last_texel == (texel.texel_index == bcdec_pkg::LAST_TEXEL)))
        else $error("last_texel does not match texel position");

    a_texel_seq: assert property (@(posedge clk) disable iff (!rst_n)
        texel.valid && texel.ready && !texel.last_texel |=>
            texel.valid && texel.texel_index == $past(texel.texel_index) + 4'd1)
        else $error("texel sequence broken inside a block");

    a_cnt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 |-> v2_reg)
        else $error("texel counter mid-block with empty palette register");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |-> !v2_reg || cnt_reg == bcdec_pkg::LAST_TEXEL)
        else $error("palette register overwritten before block finished");
`endif

endmodule
